@@ rtl/core/cda_pkg.sv @@
// Shared types, constants and calendar helper functions for the date adder.
// Used by the channel interfaces and by calendar_date_adder_top; no dependencies.
`default_nettype none

package cda_pkg;

  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int AmtW   = 16;
  localparam int AccW   = 17;
  localparam int R400W  = 9;

  localparam logic [YearW-1:0]  MaxYear     = 14'd9999;
  localparam logic [MonthW-1:0] MonthsYear  = 4'd12;
  localparam logic [AccW-1:0]   MonthsDiv   = 17'd12;
  localparam logic [AccW-1:0]   CycleDiv    = 17'd400;
  localparam logic [R400W-1:0]  CycleLast   = 9'd399;
  localparam logic [R400W-1:0]  Century1    = 9'd100;
  localparam logic [R400W-1:0]  Century2    = 9'd200;
  localparam logic [R400W-1:0]  Century3    = 9'd300;

  typedef enum logic [1:0] {
    MODE_LOAD       = 2'd0,
    MODE_ADD_DAYS   = 2'd1,
    MODE_ADD_MONTHS = 2'd2,
    MODE_NONE       = 2'd3
  } mode_e;

  // The argument is the year modulo 400.
  function automatic logic is_leap(input logic [R400W-1:0] r400);
    is_leap = (r400[1:0] == 2'b00) && (r400 != Century1) && (r400 != Century2) &&
              (r400 != Century3);
  endfunction

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    case (m)
      4'd2:                      month_days = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_days = 5'd30;
      default:                   month_days = 5'd31;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/cda_in_if.sv @@
// Input channel of the date adder: valid/ready handshake with the command word.
// Depends on cda_pkg for the field widths.
`default_nettype none

interface cda_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [cda_pkg::YearW-1:0]   new_year;
  logic [cda_pkg::MonthW-1:0]  new_month;
  logic [cda_pkg::DayW-1:0]    new_day;
  logic [cda_pkg::AmtW-1:0]    amount;

  modport source (output valid, mode, new_year, new_month, new_day, amount, input ready);
  modport sink   (input valid, mode, new_year, new_month, new_day, amount, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cda_out_if.sv @@
// Output channel of the date adder: valid/ready handshake with the result word.
// Depends on cda_pkg for the field widths.
`default_nettype none

interface cda_out_if;
  logic                        valid;
  logic                        ready;
  logic [cda_pkg::YearW-1:0]   cur_year;
  logic [cda_pkg::MonthW-1:0]  cur_month;
  logic [cda_pkg::DayW-1:0]    cur_day;
  logic                        overflow;

  modport source (output valid, cur_year, cur_month, cur_day, overflow, input ready);
  modport sink   (input valid, cur_year, cur_month, cur_day, overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/core/calendar_date_adder_top.sv @@
// Gregorian date register with day and month arithmetic, one result word per command word.
// Depends on cda_pkg, cda_in_if and cda_out_if.
`default_nettype none

// The block holds one date and takes one command word at a time; it is not ready while
// a word is at work. A single subtractor does the divisions and the day walk under a small
// sequencer. A load takes six steps of the year modulo 400. Adding months takes thirteen
// steps of the divide by twelve, then the year modulo 400. Adding days takes the year
// modulo 400, then walks forward one month per step. Mode 3 returns the held date.
// The result word sits in an output register, so the next command is taken once the
// result has been registered.
module calendar_date_adder_top (
  input  wire   clk_i,
  input  wire   rst_ni,
  cda_in_if.sink    in_i,
  cda_out_if.source out_o
);
  import cda_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVM = 3'd1;
  localparam logic [2:0] S_YADD = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_FIX  = 3'd4;
  localparam logic [2:0] S_WALK = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [YearW-1:0]  year_q, year_d;
  logic [MonthW-1:0] month_q, month_d;
  logic [DayW-1:0]   day_q, day_d;
  logic              out_vld_q, out_vld_d;

  logic [YearW-1:0]  wy_q, wy_d;
  logic [MonthW-1:0] wm_q, wm_d;
  logic [AccW-1:0]   wd_q, wd_d;
  logic [AccW-1:0]   rem_q, rem_d;
  logic [12:0]       quo_q, quo_d;
  logic [3:0]        cnt_q, cnt_d;
  mode_e             mode_q, mode_d;
  logic              ovf_q, ovf_d;

  logic [YearW-1:0]  oy_q;
  logic [MonthW-1:0] om_q;
  logic [DayW-1:0]   od_q;
  logic              oo_q;

  logic [AccW-1:0]   sub_a, sub_b;
  logic [AccW:0]     sub_diff;
  logic              sub_borrow;
  logic              leap;
  logic [DayW-1:0]   dom;
  logic [YearW:0]    ysum;
  logic [DayW-1:0]   fix_day;
  logic              accept;
  logic              out_load;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_load = (state_q == S_DONE) && (!out_vld_q || out_o.ready);

  assign leap = is_leap(rem_q[R400W-1:0]);
  assign dom  = month_days(wm_q, leap);
  assign ysum = {1'b0, year_q} + {2'b00, quo_q};
  assign fix_day = (wd_q[DayW-1:0] == '0) ? DayW'(1) :
                   ((wd_q[DayW-1:0] > dom) ? dom : wd_q[DayW-1:0]);

  // The shared subtractor.
  always_comb begin
    sub_a = (state_q == S_WALK) ? wd_q : rem_q;
    case (state_q)
      S_DIVM:  sub_b = MonthsDiv << cnt_q;
      S_MOD:   sub_b = CycleDiv << cnt_q;
      S_WALK:  sub_b = {{(AccW-DayW){1'b0}}, dom};
      default: sub_b = '0;
    endcase
    sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    sub_borrow = sub_diff[AccW];
  end

  always_comb begin
    state_d   = state_q;
    year_d    = year_q;
    month_d   = month_q;
    day_d     = day_q;
    out_vld_d = out_vld_q && !out_o.ready;
    wy_d      = wy_q;
    wm_d      = wm_q;
    wd_d      = wd_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;
    mode_d    = mode_q;
    ovf_d     = ovf_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d = mode_e'(in_i.mode);
          ovf_d  = 1'b0;
          cnt_d  = 4'd5;
          case (mode_e'(in_i.mode))
            MODE_LOAD: begin
              wy_d = (in_i.new_year > MaxYear) ? MaxYear : in_i.new_year;
              wm_d = (in_i.new_month == '0) ? MonthW'(1) :
                     ((in_i.new_month > MonthsYear) ? MonthsYear : in_i.new_month);
              wd_d = {{(AccW-DayW){1'b0}}, in_i.new_day};
              rem_d = {{(AccW-YearW){1'b0}}, wy_d};
              state_d = S_MOD;
            end
            MODE_ADD_DAYS: begin
              wy_d = year_q;
              wm_d = month_q;
              wd_d = {{(AccW-DayW){1'b0}}, day_q} + {1'b0, in_i.amount};
              rem_d = {{(AccW-YearW){1'b0}}, year_q};
              state_d = S_MOD;
            end
            MODE_ADD_MONTHS: begin
              rem_d = {{(AccW-MonthW){1'b0}}, month_q - MonthW'(1)} + {1'b0, in_i.amount};
              quo_d = '0;
              cnt_d = 4'd12;
              state_d = S_DIVM;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_DIVM: begin
        if (!sub_borrow) begin
          rem_d = sub_diff[AccW-1:0];
        end
        quo_d = {quo_q[11:0], !sub_borrow};
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == '0) begin
          state_d = S_YADD;
        end
      end
      S_YADD: begin
        if (ysum > {1'b0, MaxYear}) begin
          ovf_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          wy_d  = ysum[YearW-1:0];
          wm_d  = rem_q[MonthW-1:0] + MonthW'(1);
          wd_d  = {{(AccW-DayW){1'b0}}, day_q};
          rem_d = {{(AccW-YearW){1'b0}}, ysum[YearW-1:0]};
          cnt_d = 4'd5;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (!sub_borrow) begin
          rem_d = sub_diff[AccW-1:0];
        end
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == '0) begin
          state_d = (mode_q == MODE_ADD_DAYS) ? S_WALK : S_FIX;
        end
      end
      S_FIX: begin
        year_d  = wy_q;
        month_d = wm_q;
        day_d   = fix_day;
        state_d = S_DONE;
      end
      S_WALK: begin
        if (wy_q > MaxYear) begin
          ovf_d   = 1'b1;
          state_d = S_DONE;
        end else if (!sub_borrow && (sub_diff != '0)) begin
          wd_d = sub_diff[AccW-1:0];
          if (wm_q == MonthsYear) begin
            wm_d  = MonthW'(1);
            wy_d  = wy_q + YearW'(1);
            rem_d = (rem_q[R400W-1:0] == CycleLast) ? '0 : rem_q + AccW'(1);
          end else begin
            wm_d = wm_q + MonthW'(1);
          end
        end else begin
          year_d  = wy_q;
          month_d = wm_q;
          day_d   = wd_q[DayW-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      year_q    <= YearW'(1);
      month_q   <= MonthW'(1);
      day_q     <= DayW'(1);
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      year_q    <= year_d;
      month_q   <= month_d;
      day_q     <= day_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wy_q   <= wy_d;
    wm_q   <= wm_d;
    wd_q   <= wd_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    mode_q <= mode_d;
    ovf_q  <= ovf_d;
    if (out_load) begin
      oy_q <= year_q;
      om_q <= month_q;
      od_q <= day_q;
      oo_q <= ovf_q;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.cur_year  = oy_q;
  assign out_o.cur_month = om_q;
  assign out_o.cur_day   = od_q;
  assign out_o.overflow  = oo_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("Input was accepted twice without finishing the first word.");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (month_q >= MonthW'(1)) && (month_q <= MonthsYear))
    else $error("Held month left the range one to twelve.");

  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (day_q >= DayW'(1)) && (day_q <= DayW'(31)))
    else $error("Held day left the range one to thirty-one.");

  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    year_q <= MaxYear)
    else $error("Held year passed the largest year.");

  a_walk_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> ((wm_q >= MonthW'(1)) && (wm_q <= MonthsYear)))
    else $error("Working month left the range during the day walk.");

endmodule

`default_nettype wire

@@ verif/calendar_date_checker.sv @@
`timescale 1ns / 100ps
// Result checker for calendar_date_adder_top: watches both channels, predicts each result word
// from the accepted command words and compares. Depends on cda_pkg, cda_in_if and cda_out_if.

module calendar_date_checker (
  input  wire  clk_i,
  input  wire  rst_ni,
  cda_in_if    in_mon,
  cda_out_if   out_mon,
  output int   pending_o,
  output int   fail_count_o
);
  import cda_pkg::*;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic              overflow;
  } date_word_t;

  localparam int unsigned LastYear = 9999;
  localparam int unsigned YearMonths = 12;

  int unsigned held_year;
  int unsigned held_month;
  int unsigned held_day;
  date_word_t  expected_dates[$];
  int          mismatches;

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    logic leap;
    leap = (y % 4 == 0) && !((y % 100 == 0) && (y % 400 != 0));
    case (m)
      2:           return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  task automatic apply_command(input mode_e md, input int unsigned y_in, input int unsigned m_in,
                               input int unsigned d_in, input int unsigned amt);
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned total;
    date_word_t  result;
    logic        ovf;
    ovf = 1'b0;
    case (md)
      MODE_LOAD: begin
        y = (y_in > LastYear) ? LastYear : y_in;
        m = (m_in < 1) ? 1 : ((m_in > YearMonths) ? YearMonths : m_in);
        d = (d_in < 1) ? 1 : d_in;
        if (d > month_length(y, m)) d = month_length(y, m);
        held_year  = y;
        held_month = m;
        held_day   = d;
      end
      MODE_ADD_DAYS: begin
        // Work from the day of the year, then walk forward a month at a time.
        y = held_year;
        d = held_day + amt;
        for (m = 1; m < held_month; m++) d += month_length(y, m);
        m = 1;
        while (d > month_length(y, m) && y <= LastYear) begin
          d -= month_length(y, m);
          m++;
          if (m > YearMonths) begin
            m = 1;
            y++;
          end
        end
        if (y > LastYear) begin
          ovf = 1'b1;
        end else begin
          held_year  = y;
          held_month = m;
          held_day   = d;
        end
      end
      MODE_ADD_MONTHS: begin
        total = held_month - 1 + amt;
        y = held_year + total / YearMonths;
        m = total % YearMonths + 1;
        if (y > LastYear) begin
          ovf = 1'b1;
        end else begin
          held_year  = y;
          held_month = m;
          if (held_day > month_length(y, m)) held_day = month_length(y, m);
        end
      end
      default: begin
      end
    endcase
    result.year     = YearW'(held_year);
    result.month    = MonthW'(held_month);
    result.day      = DayW'(held_day);
    result.overflow = ovf;
    expected_dates.push_back(result);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    date_word_t got;
    date_word_t want;
    if (!rst_ni) begin
      held_year  = 1;
      held_month = 1;
      held_day   = 1;
      mismatches = 0;
      expected_dates.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // A result leaving at the same edge as a command arrives belongs to an earlier word.
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.cur_year, out_mon.cur_month, out_mon.cur_day, out_mon.overflow};
        if (expected_dates.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word %0d-%0d-%0d overflow %0b", $time,
                   got.year, got.month, got.day, got.overflow);
        end else begin
          want = expected_dates.pop_front();
          if (got !== want) begin
            mismatches++;
            $display({"%0t: result mismatch: expected %0d-%0d-%0d overflow %0b, ",
                      "got %0d-%0d-%0d overflow %0b"},
                     $time, want.year, want.month, want.day, want.overflow,
                     got.year, got.month, got.day, got.overflow);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        apply_command(mode_e'(in_mon.mode), in_mon.new_year, in_mon.new_month,
                      in_mon.new_day, in_mon.amount);
      end
      pending_o    <= expected_dates.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// Top of the date adder testbench: clock, reset, command stimulus and result-side stalls.
// Depends on cda_pkg, cda_in_if, cda_out_if, calendar_date_checker and calendar_date_adder_top.

module testbench;
  import cda_pkg::*;

  localparam int TotalWords  = 270;
  localparam int StallCycles = 300;
  localparam int HoldAtWord  = 40;
  localparam int DrainAtWord = 150;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   send_idle_pct = 8;
  int   recv_idle_pct = 62;
  int   words_sent = 0;
  bit   hold_results = 1'b0;
  bit   hold_done = 1'b0;
  bit   drain_done = 1'b0;
  int   pending;
  int   fail_count;

  cda_in_if  in_ch ();
  cda_out_if out_ch ();

  calendar_date_adder_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  calendar_date_checker date_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #5 clk_i = ~clk_i;

  task automatic send_word(input mode_e md, input int unsigned yr, input int unsigned mo,
                           input int unsigned dy, input int unsigned amt);
    if (words_sent < TotalWords / 3) begin
      send_idle_pct = 8;
      recv_idle_pct = 62;
    end else if (words_sent < 2 * TotalWords / 3) begin
      send_idle_pct = 62;
      recv_idle_pct = 8;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= md;
    in_ch.new_year  <= YearW'(yr);
    in_ch.new_month <= MonthW'(mo);
    in_ch.new_day   <= DayW'(dy);
    in_ch.amount    <= AmtW'(amt);
    do @(posedge clk_i); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic int unsigned pick_year();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return $urandom_range(9999);
    if (sel < 70) return $urandom_range(9999, 9900);
    if (sel < 80) return $urandom_range(16383);
    if (sel < 90) return $urandom_range(25, 4) * 100;
    return $urandom_range(400);
  endfunction

  function automatic int unsigned pick_amount();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) return $urandom_range(400);
    if (sel < 80) return $urandom_range(5000);
    if (sel < 95) return $urandom_range(65535);
    return (sel < 98) ? 65535 : 0;
  endfunction

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        out_ch.ready <= 1'b0;
        repeat (StallCycles) @(posedge clk_i);
        hold_results = 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= MODE_LOAD;
    in_ch.new_year  <= '0;
    in_ch.new_month <= '0;
    in_ch.new_day   <= '0;
    in_ch.amount    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_word(MODE_NONE, 0, 0, 0, 0);
    send_word(MODE_ADD_DAYS, 0, 0, 0, 0);
    send_word(MODE_LOAD, 0, 0, 0, 0);
    send_word(MODE_LOAD, 16383, 15, 31, 0);
    send_word(MODE_ADD_DAYS, 0, 0, 0, 1);
    send_word(MODE_ADD_MONTHS, 0, 0, 0, 0);
    send_word(MODE_ADD_MONTHS, 0, 0, 0, 1);
    send_word(MODE_LOAD, 2000, 2, 31, 0);
    send_word(MODE_LOAD, 1900, 2, 29, 0);
    send_word(MODE_ADD_MONTHS, 0, 0, 0, 12);
    send_word(MODE_LOAD, 2024, 1, 31, 0);
    send_word(MODE_ADD_MONTHS, 0, 0, 0, 1);
    send_word(MODE_LOAD, 2023, 12, 31, 0);
    send_word(MODE_ADD_DAYS, 0, 0, 0, 1);
    send_word(MODE_ADD_DAYS, 0, 0, 0, 65535);
    send_word(MODE_LOAD, 0, 12, 31, 0);
    send_word(MODE_ADD_MONTHS, 0, 0, 0, 65535);
    send_word(MODE_LOAD, 1, 1, 1, 0);
    send_word(MODE_ADD_DAYS, 0, 0, 0, 65535);
    send_word(MODE_LOAD, 9999, 1, 1, 0);
    send_word(MODE_ADD_DAYS, 0, 0, 0, 364);
    send_word(MODE_ADD_DAYS, 0, 0, 0, 1);
    send_word(MODE_LOAD, 2100, 4, 0, 0);
    send_word(MODE_LOAD, 2100, 4, 31, 0);
    send_word(MODE_NONE, 16383, 15, 31, 65535);

    while (words_sent < TotalWords) begin
      if (words_sent >= HoldAtWord && !hold_done) begin
        hold_results = 1'b1;
        hold_done = 1'b1;
      end
      if (words_sent >= DrainAtWord && !drain_done) begin
        wait_for_results();
        drain_done = 1'b1;
      end
      if ($urandom_range(99) < 75) begin
        send_word(MODE_LOAD, pick_year(),
                  ($urandom_range(99) < 90) ? $urandom_range(12, 1) : $urandom_range(15),
                  $urandom_range(31), $urandom_range(65535));
        repeat ($urandom_range(4, 1)) begin
          send_word(mode_e'($urandom_range(2, 1)), $urandom_range(16383), $urandom_range(15),
                    $urandom_range(31), pick_amount());
        end
      end else begin
        send_word(mode_e'($urandom_range(3)), $urandom_range(16383), $urandom_range(15),
                  $urandom_range(31), pick_amount());
      end
    end

    wait_for_results();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/cda_pkg.sv
rtl/core/cda_in_if.sv
rtl/core/cda_out_if.sv
rtl/core/calendar_date_adder_top.sv
verif/calendar_date_checker.sv
verif/testbench.sv
